FILE: hdl/bss_pkg.sv
// bss_pkg: shared types and constants for the bounded sample statistics block.
// Holds request/result payload structs, command codes and controller/datapath links.
// No dependencies.
package bss_pkg;

	localparam int CAPACITY_DEFAULT = 16;

	localparam logic [2:0] CMD_ADD     = 3'd0;
	localparam logic [2:0] CMD_REM_ONE = 3'd1;
	localparam logic [2:0] CMD_REM_ALL = 3'd2;
	localparam logic [2:0] CMD_CLEAR   = 3'd3;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] value;
	} bss_in_t;

	typedef struct packed {
		logic               accepted;
		logic [4:0]         sample_count;
		logic               found;
		logic [4:0]         occurrences;
		logic               is_empty;
		logic signed [31:0] minimum;
		logic signed [31:0] maximum;
		logic [31:0]        spread;
		logic signed [35:0] total;
		logic signed [39:0] mean_q8;
		logic [39:0]        deviation_q8;
	} bss_out_t;

	typedef enum logic [1:0] {
		IT_MUL,
		IT_DIV,
		IT_SQRT
	} it_op_t;

	typedef enum logic [2:0] {
		JOB_MEAN,
		JOB_SQ,
		JOB_NSQ,
		JOB_DEV_DIV,
		JOB_DEV_SQRT
	} job_t;

	typedef struct packed {
		logic in_take;
		logic do_add;
		logic do_clear;
		logic rd_idx;
		logic rd_last;
		logic mv_wr;
		logic idx_inc;
		logic idx_rst;
		logic stat_clr;
		logic p1_acc;
		logic p2_sub;
		logic p2_sq;
		logic p2_acc;
		logic it_start;
		job_t job;
		logic sq_save;
		logic mean_save;
		logic dev_save;
		logic out_load;
	} bss_ctl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       scan_end;
		logic       match;
		logic       n_zero;
		logic       n_one;
		logic       it_busy;
		logic       out_block;
	} bss_sts_t;

endpackage

FILE: hdl/bss_ram.sv
// bss_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module bss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/bss_iter.sv
// bss_iter: shared iterative unit; shift-add multiply, restoring divide, bitwise square root.
// Depends on bss_pkg.
module bss_iter #(
	parameter int DW  = 90,
	parameter int DVS = 10,
	parameter int MBW = 37
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  bss_pkg::it_op_t op,
	input  logic [DW-1:0]   a,
	input  logic [DW-1:0]   b,
	output logic            busy,
	output logic [DW-1:0]   res
);

	localparam int TW = $clog2(DW + 1);

	bss_pkg::it_op_t op_q;
	logic            busy_q;
	logic [TW-1:0]   steps_q;
	logic [DW-1:0]   x_q, y_q, z_q;
	logic [DVS-1:0]  rem_q;

	logic [DW-1:0]   mul_sum;
	logic [DVS:0]    rem_sh, d_ext, rem_diff;
	logic            div_ge;
	logic [DW-1:0]   sq_t;
	logic            sq_ge;

	always_comb begin
		mul_sum  = {x_q[DW-2:0], 1'b0} + (y_q[MBW-1] ? z_q : '0);
		rem_sh   = {rem_q, x_q[DW-1]};
		d_ext    = {1'b0, z_q[DVS-1:0]};
		div_ge   = rem_sh >= d_ext;
		rem_diff = rem_sh - d_ext;
		sq_t     = y_q + z_q;
		sq_ge    = x_q >= sq_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			steps_q <= '0;
			op_q    <= bss_pkg::IT_MUL;
		end else if (start) begin
			busy_q <= 1'b1;
			op_q   <= op;
			unique case (op)
				bss_pkg::IT_MUL:  steps_q <= TW'(MBW);
				bss_pkg::IT_DIV:  steps_q <= TW'(DW);
				default:          steps_q <= TW'(DW / 2);
			endcase
		end else if (busy_q) begin
			steps_q <= steps_q - TW'(1);
			if (steps_q == TW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			unique case (op)
				bss_pkg::IT_MUL: begin
					x_q <= '0;
					y_q <= b;
					z_q <= a;
				end
				bss_pkg::IT_DIV: begin
					x_q   <= a;
					z_q   <= b;
					rem_q <= '0;
				end
				default: begin
					x_q <= a;
					y_q <= '0;
					z_q <= {2'b01, {(DW - 2){1'b0}}};
				end
			endcase
		end else if (busy_q) begin
			unique case (op_q)
				bss_pkg::IT_MUL: begin
					x_q <= mul_sum;
					y_q <= {y_q[DW-2:0], 1'b0};
				end
				bss_pkg::IT_DIV: begin
					rem_q <= div_ge ? rem_diff[DVS-1:0] : rem_sh[DVS-1:0];
					x_q   <= {x_q[DW-2:0], div_ge};
				end
				default: begin
					if (sq_ge) begin
						x_q <= x_q - sq_t;
						y_q <= (y_q >> 1) + z_q;
					end else begin
						y_q <= y_q >> 1;
					end
					z_q <= z_q >> 2;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign res  = (op_q == bss_pkg::IT_SQRT) ? y_q : x_q;

endmodule

FILE: hdl/bss_dp.sv
// bss_dp: datapath; sample store, scan accumulators, iterative unit and result register.
// Depends on bss_pkg, bss_ram, bss_iter.
module bss_dp #(
	parameter int CAPACITY = bss_pkg::CAPACITY_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bss_pkg::bss_ctl_t ctl,
	output bss_pkg::bss_sts_t sts,
	input  bss_pkg::bss_in_t  req,
	input  logic              rsp_stall,
	output logic              rsp_valid,
	output bss_pkg::bss_out_t rsp
);

	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int IW  = $clog2(CAPACITY);
	localparam int SW  = 32 + CW;
	localparam int S2W = 64 + CW;
	localparam int PW  = 64 + 2 * CW;
	localparam int DW  = PW + 16;
	localparam int DVS = 2 * CW;

	logic [2:0]         cmd_q;
	logic [31:0]        val_q;
	logic [CW-1:0]      cnt_q, idx_q, occ_q;
	logic               acc_q;
	logic signed [31:0] mn_q, mx_q;
	logic signed [SW-1:0] sum_q;
	logic [SW-1:0]      sy_q;
	logic [31:0]        y_s1;
	logic [63:0]        yy_s2;
	logic [S2W-1:0]     sy2_q;
	logic [PW-1:0]      sq_q;
	logic [39:0]        mean_q, dev_q;
	bss_pkg::bss_out_t  out_q;
	logic               out_valid_q;

	logic               ram_we, ram_re;
	logic [IW-1:0]      ram_waddr, ram_raddr;
	logic [31:0]        ram_wdata, ram_rdata;

	logic               full, first, match;
	logic [CW-1:0]      cnt_last;
	logic signed [31:0] samp;
	logic [31:0]        y_diff;
	logic [SW-1:0]      abs_sum;
	logic [DVS-1:0]     nn;
	logic [PW-1:0]      d_val;
	bss_pkg::it_op_t    it_op;
	logic [DW-1:0]      it_a, it_b, it_res;
	logic               it_busy;
	logic [39:0]        mean_val, dev_val;

	bss_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bss_iter #(.DW(DW), .DVS(DVS), .MBW(SW)) u_iter (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctl.it_start),
		.op    (it_op),
		.a     (it_a),
		.b     (it_b),
		.busy  (it_busy),
		.res   (it_res)
	);

	always_comb begin
		full      = cnt_q == CW'(CAPACITY);
		cnt_last  = cnt_q - CW'(1);
		ram_we    = (ctl.do_add && !full) || ctl.mv_wr;
		ram_waddr = ctl.mv_wr ? idx_q[IW-1:0] : cnt_q[IW-1:0];
		ram_wdata = ctl.mv_wr ? ram_rdata : val_q;
		ram_re    = ctl.rd_idx || ctl.rd_last;
		ram_raddr = ctl.rd_last ? cnt_last[IW-1:0] : idx_q[IW-1:0];
		samp      = signed'(ram_rdata);
		first     = idx_q == '0;
		match     = ram_rdata == val_q;
		y_diff    = ram_rdata - unsigned'(mn_q);
		abs_sum   = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
		nn        = DVS'(cnt_q) * DVS'(cnt_last);
		d_val     = it_res[PW-1:0] - sq_q;
		mean_val  = sum_q[SW-1] ? 40'(-it_res) : it_res[39:0];
		dev_val   = (|it_res[DW-1:40]) ? '1 : it_res[39:0];

		// pick operands for the iterative unit
		case (ctl.job)
			bss_pkg::JOB_MEAN: begin
				it_op = bss_pkg::IT_DIV;
				it_a  = DW'({abs_sum, 8'b0});
				it_b  = DW'(cnt_q);
			end
			bss_pkg::JOB_SQ: begin
				it_op = bss_pkg::IT_MUL;
				it_a  = DW'(sy_q);
				it_b  = DW'(sy_q);
			end
			bss_pkg::JOB_NSQ: begin
				it_op = bss_pkg::IT_MUL;
				it_a  = DW'(sy2_q);
				it_b  = DW'(cnt_q);
			end
			bss_pkg::JOB_DEV_DIV: begin
				it_op = bss_pkg::IT_DIV;
				it_a  = {d_val, 16'b0};
				it_b  = DW'(nn);
			end
			default: begin
				it_op = bss_pkg::IT_SQRT;
				it_a  = it_res;
				it_b  = '0;
			end
		endcase

		sts.cmd       = cmd_q;
		sts.scan_end  = idx_q >= cnt_q;
		sts.match     = match;
		sts.n_zero    = cnt_q == '0;
		sts.n_one     = cnt_q == CW'(1);
		sts.it_busy   = it_busy;
		sts.out_block = out_valid_q && rsp_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.do_add && !full) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (ctl.do_clear) begin
				cnt_q <= '0;
			end else if (ctl.mv_wr) begin
				cnt_q <= cnt_last;
			end
			if (ctl.idx_rst) begin
				idx_q <= '0;
			end else if (ctl.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.in_take) begin
			cmd_q <= req.cmd;
			val_q <= req.value;
			acc_q <= 1'b1;
		end
		if (ctl.do_add && full) begin
			acc_q <= 1'b0;
		end
		if (ctl.stat_clr) begin
			occ_q  <= '0;
			mn_q   <= '0;
			mx_q   <= '0;
			sum_q  <= '0;
			sy_q   <= '0;
			sy2_q  <= '0;
			mean_q <= '0;
			dev_q  <= '0;
		end
		if (ctl.p1_acc) begin
			occ_q <= occ_q + CW'(match);
			if (first || samp < mn_q) begin
				mn_q <= samp;
			end
			if (first || samp > mx_q) begin
				mx_q <= samp;
			end
			sum_q <= sum_q + SW'(samp);
		end
		if (ctl.p2_sub) begin
			y_s1 <= y_diff;
			sy_q <= sy_q + SW'(y_diff);
		end
		if (ctl.p2_sq) begin
			yy_s2 <= y_s1 * y_s1;
		end
		if (ctl.p2_acc) begin
			sy2_q <= sy2_q + S2W'(yy_s2);
		end
		if (ctl.sq_save) begin
			sq_q <= it_res[PW-1:0];
		end
		if (ctl.mean_save) begin
			mean_q <= mean_val;
		end
		if (ctl.dev_save) begin
			dev_q <= dev_val;
		end
		if (ctl.out_load) begin
			out_q.accepted     <= acc_q;
			out_q.sample_count <= 5'(cnt_q);
			out_q.found        <= occ_q != '0;
			out_q.occurrences  <= 5'(occ_q);
			out_q.is_empty     <= cnt_q == '0;
			out_q.minimum      <= mn_q;
			out_q.maximum      <= mx_q;
			out_q.spread       <= 32'(mx_q - mn_q);
			out_q.total        <= 36'(sum_q);
			out_q.mean_q8      <= signed'(mean_q);
			out_q.deviation_q8 <= dev_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("held count above capacity");
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.do_add && !full |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("add did not grow the count");
	a_move_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mv_wr |=> cnt_q == $past(cnt_q) - CW'(1))
		else $error("removal did not shrink the count");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load && cnt_q == '0 |=> rsp.is_empty && rsp.total == '0
			&& rsp.deviation_q8 == '0 && rsp.mean_q8 == '0)
		else $error("empty set reported nonzero statistics");
`endif

endmodule

FILE: hdl/bss_ctrl.sv
// bss_ctrl: controller state machine sequencing command, scan passes and arithmetic jobs.
// Depends on bss_pkg.
module bss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  bss_pkg::bss_sts_t sts,
	output bss_pkg::bss_ctl_t ctl
);

	typedef enum logic [16:0] {
		S_IDLE     = 17'h00001,
		S_CMD      = 17'h00002,
		S_SCAN_RD  = 17'h00004,
		S_SCAN_CMP = 17'h00008,
		S_MOVE     = 17'h00010,
		S_P1_RD    = 17'h00020,
		S_P1_ACC   = 17'h00040,
		S_MEAN     = 17'h00080,
		S_P2_RD    = 17'h00100,
		S_P2_SUB   = 17'h00200,
		S_P2_SQ    = 17'h00400,
		S_P2_ACC   = 17'h00800,
		S_MUL_SQ   = 17'h01000,
		S_MUL_N    = 17'h02000,
		S_DIV      = 17'h04000,
		S_SQRT     = 17'h08000,
		S_FIN      = 17'h10000
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.in_take = 1'b1;
					state_nx    = S_CMD;
				end
			end
			S_CMD: begin
				case (sts.cmd)
					bss_pkg::CMD_REM_ONE, bss_pkg::CMD_REM_ALL: begin
						ctl.idx_rst = 1'b1;
						state_nx    = S_SCAN_RD;
					end
					default: begin
						ctl.do_add   = sts.cmd == bss_pkg::CMD_ADD;
						ctl.do_clear = sts.cmd == bss_pkg::CMD_CLEAR;
						ctl.idx_rst  = 1'b1;
						ctl.stat_clr = 1'b1;
						state_nx     = S_P1_RD;
					end
				endcase
			end
			S_SCAN_RD: begin
				if (sts.scan_end) begin
					ctl.idx_rst  = 1'b1;
					ctl.stat_clr = 1'b1;
					state_nx     = S_P1_RD;
				end else begin
					ctl.rd_idx = 1'b1;
					state_nx   = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (sts.match) begin
					ctl.rd_last = 1'b1;
					state_nx    = S_MOVE;
				end else begin
					ctl.idx_inc = 1'b1;
					state_nx    = S_SCAN_RD;
				end
			end
			S_MOVE: begin
				// fill the gap with the last sample; remove-all rechecks the same slot
				ctl.mv_wr = 1'b1;
				if (sts.cmd == bss_pkg::CMD_REM_ONE) begin
					ctl.idx_rst  = 1'b1;
					ctl.stat_clr = 1'b1;
					state_nx     = S_P1_RD;
				end else begin
					state_nx = S_SCAN_RD;
				end
			end
			S_P1_RD: begin
				if (!sts.scan_end) begin
					ctl.rd_idx = 1'b1;
					state_nx   = S_P1_ACC;
				end else if (sts.n_zero) begin
					state_nx = S_FIN;
				end else begin
					ctl.it_start = 1'b1;
					ctl.job      = bss_pkg::JOB_MEAN;
					state_nx     = S_MEAN;
				end
			end
			S_P1_ACC: begin
				ctl.p1_acc  = 1'b1;
				ctl.idx_inc = 1'b1;
				state_nx    = S_P1_RD;
			end
			S_MEAN: begin
				ctl.job = bss_pkg::JOB_MEAN;
				if (!sts.it_busy) begin
					ctl.mean_save = 1'b1;
					if (sts.n_one) begin
						state_nx = S_FIN;
					end else begin
						ctl.idx_rst = 1'b1;
						state_nx    = S_P2_RD;
					end
				end
			end
			S_P2_RD: begin
				if (sts.scan_end) begin
					ctl.it_start = 1'b1;
					ctl.job      = bss_pkg::JOB_SQ;
					state_nx     = S_MUL_SQ;
				end else begin
					ctl.rd_idx = 1'b1;
					state_nx   = S_P2_SUB;
				end
			end
			S_P2_SUB: begin
				ctl.p2_sub = 1'b1;
				state_nx   = S_P2_SQ;
			end
			S_P2_SQ: begin
				ctl.p2_sq = 1'b1;
				state_nx  = S_P2_ACC;
			end
			S_P2_ACC: begin
				ctl.p2_acc  = 1'b1;
				ctl.idx_inc = 1'b1;
				state_nx    = S_P2_RD;
			end
			S_MUL_SQ: begin
				if (!sts.it_busy) begin
					ctl.sq_save  = 1'b1;
					ctl.it_start = 1'b1;
					ctl.job      = bss_pkg::JOB_NSQ;
					state_nx     = S_MUL_N;
				end
			end
			S_MUL_N: begin
				if (!sts.it_busy) begin
					ctl.it_start = 1'b1;
					ctl.job      = bss_pkg::JOB_DEV_DIV;
					state_nx     = S_DIV;
				end
			end
			S_DIV: begin
				if (!sts.it_busy) begin
					ctl.it_start = 1'b1;
					ctl.job      = bss_pkg::JOB_DEV_SQRT;
					state_nx     = S_SQRT;
				end
			end
			S_SQRT: begin
				if (!sts.it_busy) begin
					ctl.dev_save = 1'b1;
					state_nx     = S_FIN;
				end
			end
			S_FIN: begin
				if (!sts.out_block) begin
					ctl.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign req_stall = state_q != S_IDLE;

endmodule

FILE: hdl/bounded_sample_statistics.sv
// bounded_sample_statistics: top level of the bounded sample statistics block.
// Depends on bss_pkg, bss_ctrl, bss_dp (and through it bss_ram, bss_iter).
//
// Usage:
//   Request channel (req_valid/req_stall/req) carries one command: add a sample,
//   remove the first or every copy of a value, clear, or query. The result channel
//   (rsp_valid/rsp_stall/rsp) returns one result per request: count, presence and
//   count of the value, min, max, range, sum, Q8 mean and Q8 sample deviation.
//   Requests are processed one at a time; req_stall is low only while idle.
//   After the command, a first pass over the held samples gathers occurrences,
//   min, max and sum; if any are held, the mean is then divided out, and with
//   more than one sample a second pass and a multiply, multiply, divide and
//   square root follow for the deviation. A removal first scans the samples
//   held before it. All arithmetic shares one iterative multiply/divide/root
//   unit, and samples are read from the store one at a time.
//   Results sit in an output register: when the receiver stalls, the block still
//   takes the next request and only waits at the end of that request's work
//   until the register frees up. Reset empties the set and drops any pending
//   result; the sample RAM itself is not cleared.
module bounded_sample_statistics #(
	parameter int CAPACITY = bss_pkg::CAPACITY_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  bss_pkg::bss_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output bss_pkg::bss_out_t rsp
);

	// command and status between sequencer and datapath
	bss_pkg::bss_ctl_t ctl;
	bss_pkg::bss_sts_t sts;

	bss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	// datapath: store, scan accumulators, arithmetic unit and result register
	bss_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.req      (req),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

endmodule
